@@ rtl/itoa_pkg.sv @@
// Shared constants, command/status types and the digit encoder for the ASCII converter.
package itoa_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned DigitWidth = 4;
  // An unsigned 32-bit word has at most ten decimal digits.
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CountWidth = $clog2(MaxDigits + 1);
  localparam int unsigned IndexWidth = $clog2(MaxDigits);

  localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CHAR_ZERO = 8'h30;
  // 'A' minus ten, so that a digit of ten maps to 'A'.
  localparam logic [CharWidth-1:0] CHAR_ALPHA_BIAS = 8'h37;

  // ceil(2^35 / 10); (x * RECIP_10) >> 35 equals x / 10 for every 32-bit x.
  localparam logic [WordWidth-1:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
  } itoa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic last_char;
  } itoa_status_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] ext;
    ext = {{(CharWidth - DigitWidth){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_ALPHA_BIAS + ext;
    end
  endfunction

endpackage

@@ rtl/itoa_in_if.sv @@
// Input channel: one word with its base choice and signed flag per request.
interface itoa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        base_select;
  logic        signed_mode;

  modport source (output valid, output value, output base_select, output signed_mode,
                  input ready);
  modport sink (input valid, input value, input base_select, input signed_mode,
                output ready);
endinterface

@@ rtl/itoa_out_if.sv @@
// Output channel: one ASCII character and its last flag per request.
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/itoa_datapath.sv @@
// Datapath: magnitude register, digit extraction unit, digit buffer and character select.
module itoa_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  itoa_pkg::itoa_cmd_t                cmd,
  output itoa_pkg::itoa_status_t             status,
  input  logic [itoa_pkg::WordWidth-1:0]     value,
  input  logic                               base_select,
  input  logic                               signed_mode,
  output logic [itoa_pkg::CharWidth-1:0]     character,
  output logic                               last
);
  import itoa_pkg::*;

  logic [WordWidth-1:0]  mag;
  logic                  hex;
  logic                  sign_pending;
  logic [CountWidth-1:0] cnt;
  logic [DigitWidth-1:0] digits [MaxDigits];

  logic [2*WordWidth-1:0] prod;
  logic [WordWidth-1:0]   quot_dec;
  logic [WordWidth-1:0]   quot_times_ten;
  logic [WordWidth-1:0]   rem_dec;
  logic [WordWidth-1:0]   quot;
  logic [DigitWidth-1:0]  rem;
  logic [CountWidth-1:0]  cnt_minus_one;
  logic                   load_negative;

  // Decimal digit by reciprocal multiplication; the remainder is recovered with shifts.
  assign prod = {{WordWidth{1'b0}}, mag} * {{WordWidth{1'b0}}, RECIP_10};
  assign quot_dec = {{(RecipShift - WordWidth){1'b0}}, prod[2*WordWidth-1:RecipShift]};
  assign quot_times_ten = (quot_dec << 3) + (quot_dec << 1);
  assign rem_dec = mag - quot_times_ten;

  always_comb begin
    if (hex) begin
      quot = {4'b0, mag[WordWidth-1:DigitWidth]};
      rem = mag[DigitWidth-1:0];
    end else begin
      quot = quot_dec;
      rem = rem_dec[DigitWidth-1:0];
    end
  end

  assign load_negative = signed_mode & value[WordWidth-1];
  assign cnt_minus_one = cnt - 1'b1;

  // The step that stores the tenth digit always finishes the conversion.
  assign status.conv_done = (quot == '0) || (cnt == CountWidth'(MaxDigits - 1));
  assign status.last_char = !sign_pending && (cnt == CountWidth'(1));

  assign character = sign_pending ? CHAR_MINUS
                                  : digit_char(digits[cnt_minus_one[IndexWidth-1:0]]);
  assign last = status.last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sign_pending <= 1'b0;
    end else begin
      priority if (cmd.load) begin
        cnt <= '0;
        sign_pending <= load_negative;
      end else if (cmd.step) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.advance) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else begin
          cnt <= cnt_minus_one;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= load_negative ? (WordWidth'(0) - value) : value;
      hex <= base_select;
    end else if (cmd.step) begin
      mag <= quot;
      digits[cnt[IndexWidth-1:0]] <= rem;
    end
  end

endmodule

@@ rtl/itoa_ctrl.sv @@
// Controller: sequences load, digit extraction and character output for one word.
module itoa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  itoa_pkg::itoa_status_t status,
  output itoa_pkg::itoa_cmd_t    cmd
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);
  assign out_valid = (state == EMIT);

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.step = (state == CONVERT);
    cmd.advance = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CONVERT;
          end
        end
        CONVERT: begin
          if (status.conv_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_ready && status.last_char) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// Top level: 32-bit word to decimal or upper-case hex ASCII text, one character per request.
// A word of D digits and N characters (N = D, plus one for a minus sign) passes through digit
// extraction after the input request, one digit per cycle through the divide-by-ten reciprocal
// multiplier or the hex shift; the first character is offered once all digits are stored.
// The next word waits until the last character is accepted; the longest text is "-2147483648".
// Synchronous active-high reset returns the controller to idle; no request is in flight.
module integer_to_ascii_digits (
  input  logic        clk,
  input  logic        rst,
  itoa_in_if.sink     data_in,
  itoa_out_if.source  char_out
);
  import itoa_pkg::*;

  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (data_in.valid),
    .in_ready  (data_in.ready),
    .out_valid (char_out.valid),
    .out_ready (char_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  itoa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (data_in.value),
    .base_select (data_in.base_select),
    .signed_mode (data_in.signed_mode),
    .character   (char_out.character),
    .last        (char_out.last)
  );

endmodule
